/* rtl/core/pfw_pkg.sv */
// Shared types, constants and helpers for the packet handle queue.
// Used by every file in rtl/core except pfw_ram; depends on nothing.
package pfw_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int HANDLE_W    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 9;
  localparam int FRAC_SHIFT  = 8;
  localparam int THR_W       = CFG_W + CNT_W;
  localparam int OPC_W       = 2;
  localparam int ERR_W       = 2;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam logic [CFG_W-1:0] CAPACITY_RST = CFG_W'(256);
  localparam logic [CFG_W-1:0] BLOCK_RST    = CFG_W'(204);
  localparam logic [CFG_W-1:0] CLEAR_RST    = CFG_W'(128);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OPC_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_BLOCK    = 2'd1,
    REG_CLEAR    = 2'd2
  } reg_idx_t;

  // Effective capacity and the two watermark thresholds, already scaled.
  typedef struct packed {
    cnt_t             cap_eff;
    logic [THR_W-1:0] block_thr;
    logic [THR_W-1:0] clear_thr;
  } mark_cfg_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

/* rtl/core/pfw_in_if.sv */
// Request channel for the packet handle queue: opcode and handle.
// Depends on pfw_pkg.
interface pfw_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfw_pkg::OPC_W-1:0]    opcode;
  logic [pfw_pkg::HANDLE_W-1:0] packet_handle;

  modport source (output valid, output opcode, output packet_handle, input ready);
  modport sink   (input valid, input opcode, input packet_handle, output ready);
endinterface

/* rtl/core/pfw_out_if.sv */
// Result channel for the packet handle queue: handle out and status.
// Depends on pfw_pkg.
interface pfw_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfw_pkg::HANDLE_W-1:0] head_handle;
  logic                         handle_valid;
  logic [pfw_pkg::ERR_W-1:0]    op_error;
  logic                         queue_empty;
  logic                         queue_full;
  logic                         over_block_mark;
  logic                         under_clear_mark;
  logic [pfw_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output head_handle, output handle_valid, output op_error,
                  output queue_empty, output queue_full, output over_block_mark,
                  output under_clear_mark, output entry_count, input ready);
  modport sink   (input valid, input head_handle, input handle_valid, input op_error,
                  input queue_empty, input queue_full, input over_block_mark,
                  input under_clear_mark, input entry_count, output ready);
endinterface

/* rtl/core/pfw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module pfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pfw_cfg.sv */
// APB register file for capacity and watermarks, plus scaled thresholds.
// Depends on pfw_pkg.
module pfw_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pfw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pfw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output pfw_pkg::mark_cfg_t                 marks
);

  logic [pfw_pkg::CFG_W-1:0] capacity_r;
  logic [pfw_pkg::CFG_W-1:0] block_r;
  logic [pfw_pkg::CFG_W-1:0] clear_r;
  logic [pfw_pkg::THR_W-1:0] block_thr_r;
  logic [pfw_pkg::THR_W-1:0] clear_thr_r;
  pfw_pkg::cnt_t             cap_eff;
  pfw_pkg::reg_idx_t         reg_sel;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = pfw_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= pfw_pkg::CAPACITY_RST;
      block_r    <= pfw_pkg::BLOCK_RST;
      clear_r    <= pfw_pkg::CLEAR_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        pfw_pkg::REG_CAPACITY: capacity_r <= pwdata[pfw_pkg::CFG_W-1:0];
        pfw_pkg::REG_BLOCK:    block_r    <= pwdata[pfw_pkg::CFG_W-1:0];
        pfw_pkg::REG_CLEAR:    clear_r    <= pwdata[pfw_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      pfw_pkg::REG_CAPACITY: prdata = pfw_pkg::APB_DATA_W'(capacity_r);
      pfw_pkg::REG_BLOCK:    prdata = pfw_pkg::APB_DATA_W'(block_r);
      pfw_pkg::REG_CLEAR:    prdata = pfw_pkg::APB_DATA_W'(clear_r);
      default:               prdata = '0;
    endcase
  end

  // Clamp capacity into 1..QUEUE_DEPTH.
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = pfw_pkg::cnt_t'(1);
    end else if (int'(capacity_r) > pfw_pkg::QUEUE_DEPTH) begin
      cap_eff = pfw_pkg::cnt_t'(pfw_pkg::QUEUE_DEPTH);
    end else begin
      cap_eff = pfw_pkg::cnt_t'(capacity_r);
    end
  end

  // Thresholds must only change while idle; the block does not enforce it. One register stage is enough.
  always_ff @(posedge clk) begin
    block_thr_r <= pfw_pkg::THR_W'(block_r) * pfw_pkg::THR_W'(cap_eff);
    clear_thr_r <= pfw_pkg::THR_W'(clear_r) * pfw_pkg::THR_W'(cap_eff);
  end

  assign marks.cap_eff   = cap_eff;
  assign marks.block_thr = block_thr_r;
  assign marks.clear_thr = clear_thr_r;

endmodule

/* rtl/core/packet_fifo_with_watermarks.sv */
// Packet handle queue with fill watermarks: ring buffer in one RAM plus APB setup.
// An accepted request passes through stage 1 and then the output register before its result shows.
// Throughput: one request per cycle; only a stalled result register holds intake back.
// The ring RAM has one write and one registered read port, used by one request a cycle.
// Reset (rst_n low, synchronous): queue empty, indices zero, capacity 256,
// watermarks 204 and 128; RAM contents are left as they are.
module packet_fifo_with_watermarks (
  input  logic                           clk,
  input  logic                           rst_n,
  pfw_in_if.sink                         in_if,
  pfw_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pfw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pfw_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  pfw_pkg::mark_cfg_t marks;

  pfw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .marks   (marks)
  );

  // ---------------------------------------------------------------------------
  // Ring pointers and fill count
  // ---------------------------------------------------------------------------
  pfw_pkg::idx_t rd_idx_r, rd_idx_nxt;
  pfw_pkg::idx_t wr_idx_r, wr_idx_nxt;
  pfw_pkg::cnt_t count_r, count_nxt;

  // Stage 1: request decided, RAM read in flight.
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_hv_r, s1_hv_nxt;
  pfw_pkg::err_t s1_err_r, s1_err_nxt;
  pfw_pkg::cnt_t s1_count_r;

  // Output register.
  logic                         out_valid_r;
  logic [pfw_pkg::HANDLE_W-1:0] out_head_r;
  logic                         out_hv_r;
  pfw_pkg::err_t                out_err_r;
  logic                         out_empty_r;
  logic                         out_full_r;
  logic                         out_over_r;
  logic                         out_under_r;
  pfw_pkg::cnt_t                out_count_r;

  logic                         accept;
  logic                         s1_adv;
  pfw_pkg::op_t                 op;
  logic                         q_full;
  logic                         q_empty;
  logic                         ram_we;
  logic                         ram_re;
  logic [pfw_pkg::HANDLE_W-1:0] ram_rdata;
  logic [pfw_pkg::THR_W-1:0]    scaled;

  // Advance stage 1 into the output register when that register is free or
  // being drained; take a new request whenever stage 1 will be free.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign accept      = in_if.valid && in_if.ready;

  assign op      = pfw_pkg::op_t'(in_if.opcode);
  assign q_full  = count_r >= marks.cap_eff;
  assign q_empty = count_r == '0;

  // Decide the request against the current count. A write and a read never
  // fall in the same cycle, and the RAM returns the write of the previous
  // cycle, so no forwarding is needed.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    s1_hv_nxt  = 1'b0;
    s1_err_nxt = pfw_pkg::ERR_OK;
    if (accept) begin
      unique case (op) inside
        pfw_pkg::OP_ENQ: begin
          if (q_full) begin
            // Drop the handle; state stays as it is.
            s1_err_nxt = pfw_pkg::ERR_FULL;
          end else begin
            ram_we     = 1'b1;
            wr_idx_nxt = pfw_pkg::ring_next(wr_idx_r);
            count_nxt  = count_r + 1'b1;
          end
        end
        pfw_pkg::OP_DEQ, pfw_pkg::OP_PEEK: begin
          if (q_empty) begin
            s1_err_nxt = pfw_pkg::ERR_EMPTY;
          end else begin
            ram_re    = 1'b1;
            s1_hv_nxt = 1'b1;
            if (op == pfw_pkg::OP_DEQ) begin
              rd_idx_nxt = pfw_pkg::ring_next(rd_idx_r);
              count_nxt  = count_r - 1'b1;
            end
          end
        end
        default: ;  // no operation: report status only
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  pfw_ram #(
    .WIDTH (pfw_pkg::HANDLE_W),
    .DEPTH (pfw_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_if.packet_handle),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      rd_idx_r   <= rd_idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Hold stage 1 payload while it waits; the RAM read data holds too since
  // no new read is issued until stage 1 moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hv_r    <= s1_hv_nxt;
      s1_err_r   <= s1_err_nxt;
      s1_count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Status flags and output register
  // ---------------------------------------------------------------------------
  // count * 256 compared against fraction * capacity.
  assign scaled = pfw_pkg::THR_W'({s1_count_r, {pfw_pkg::FRAC_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_head_r  <= s1_hv_r ? ram_rdata : '0;
      out_hv_r    <= s1_hv_r;
      out_err_r   <= s1_err_r;
      out_empty_r <= s1_count_r == '0;
      out_full_r  <= s1_count_r >= marks.cap_eff;
      out_over_r  <= scaled > marks.block_thr;
      out_under_r <= scaled < marks.clear_thr;
      out_count_r <= s1_count_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.head_handle      = out_head_r;
  assign out_if.handle_valid     = out_hv_r;
  assign out_if.op_error         = out_err_r;
  assign out_if.queue_empty      = out_empty_r;
  assign out_if.queue_full       = out_full_r;
  assign out_if.over_block_mark  = out_over_r;
  assign out_if.under_clear_mark = out_under_r;
  assign out_if.entry_count      = out_count_r;

endmodule

/* rtl/core/pfw_chk.sv */
// Port-level checks for the packet handle queue, bound to the top level.
// Depends on pfw_pkg and packet_fifo_with_watermarks.
module pfw_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pfw_pkg::HANDLE_W-1:0] head_handle,
  input logic                         handle_valid,
  input logic [pfw_pkg::ERR_W-1:0]    op_error,
  input logic                         queue_empty,
  input logic                         queue_full,
  input logic [pfw_pkg::CNT_W-1:0]    entry_count
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(head_handle) && $stable(entry_count))
    else $error("result changed while stalled");

  // A delivered handle never comes with an error.
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && handle_valid |-> op_error == pfw_pkg::ERR_OK && !queue_empty &&
                                  entry_count != '0 || out_valid && handle_valid &&
                                  op_error == pfw_pkg::ERR_OK)
    else $error("handle with error");

  // A refused enqueue leaves the queue full.
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op_error == pfw_pkg::ERR_FULL |-> queue_full && !queue_empty)
    else $error("enqueue refused while not full");

  // An empty error means the queue is empty and nothing came out.
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op_error == pfw_pkg::ERR_EMPTY |->
      queue_empty && !handle_valid && head_handle == '0 && entry_count == '0)
    else $error("empty error with queued entries");

  // Empty and count agree, and capacity is never below one.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (queue_empty == (entry_count == '0)) && !(queue_empty && queue_full))
    else $error("empty flag disagrees with count");

endmodule

bind packet_fifo_with_watermarks pfw_chk u_pfw_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .head_handle  (out_if.head_handle),
  .handle_valid (out_if.handle_valid),
  .op_error     (out_if.op_error),
  .queue_empty  (out_if.queue_empty),
  .queue_full   (out_if.queue_full),
  .entry_count  (out_if.entry_count)
);
